### rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// shared types and constants of the bitmap block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int POOL_BYTES = 65536;
    localparam int WORD_W     = 32;
    localparam int WORDS      = MAX_BLOCKS / WORD_W;
    localparam int WADDR_W    = $clog2(WORDS);
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ADDR_W     = 32;
    localparam int OFS_W      = 16;
    localparam int BSZ_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_FREE    = 3'd1;
    localparam logic [2:0] ST_NULL       = 3'd2;
    localparam logic [2:0] ST_RANGE      = 3'd3;
    localparam logic [2:0] ST_MISALIGNED = 3'd4;
    localparam logic [2:0] ST_DOUBLE     = 3'd5;

    typedef struct packed {
        logic              kind;
        logic              addr_is_null;
        logic [ADDR_W-1:0] address;
    } req_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [OFS_W-1:0] block_offset;
        logic [IDX_W-1:0] blk_idx;
        logic             pool_full;
        logic             pool_empty;
        logic [CNT_W-1:0] used_blocks;
    } rsp_t;

endpackage

### rtl/bitmap_block_allocator_top.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator_top
// fixed-size block pool with a used/free bitmap and next-fit search
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one request (allocate or release) per handshake
//   m_ channel: exactly one result per request, in order
//   cfg channel: register writes, always ready; the user must write only while idle, the block does not enforce it
// sequence
//   allocate: a read and a check per 32-bit bitmap word, over up to two
//   search passes covering the whole map, then a multiply; full pool refused
//   release: runs the 16-step restoring divider that
//   checks the offset against the block size, then one read-modify-write;
//   a rejected offset ends after the divider, a null or out-of-range one
//   goes straight to the result; one request at a time, a new request is
//   taken once the previous result sits in the output register
// reset
//   all blocks free (per-word valid flags clear at once), used count and
//   next-fit hint zero, registers at their defaults
// stall
//   a held result keeps the next request waiting in its result state
// ----------------------------------------------------------------------------
module bitmap_block_allocator_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  bba_pkg::req_t                 s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output bba_pkg::rsp_t                 m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bba_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bba_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_MUL, S_DIV, S_DCHK,
        S_REL_RD, S_REL_CHK, S_RES
    } state_t;

    state_t             state_reg;
    logic [BSZ_W-1:0]   bsz_reg;
    logic [OFS_W-1:0]   doff_reg;
    logic [CNT_W-1:0]   bcnt_reg;
    logic [WORDS-1:0]   wvalid_reg;
    logic [CNT_W-1:0]   used_reg;
    logic [CNT_W-1:0]   hint_reg;
    logic [CNT_W-1:0]   lo_reg;
    logic [WADDR_W-1:0] word_reg;
    logic               pass_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [2:0]         status_reg;
    logic [31:0]        prod_reg;
    logic [OFS_W-1:0]   ofs_reg;
    logic [BSZ_W-1:0]   rem_reg;
    logic [OFS_W-1:0]   quo_reg;
    logic [3:0]         dcnt_reg;
    logic               out_valid_reg;
    rsp_t               out_reg;

    logic [CNT_W-1:0]   cnt;
    logic [BSZ_W-1:0]   bsz;
    logic [WORD_W-1:0]  rdata;
    logic [WORD_W-1:0]  word_data;
    logic [WORD_W-1:0]  cand;
    logic               found;
    logic [BIT_W-1:0]   first;
    logic [CNT_W-1:0]   pos;
    logic [CNT_W-1:0]   next_base;
    logic               ram_we;
    logic [WADDR_W-1:0] ram_addr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [BSZ_W-1:0]   shifted;
    logic               rel_bit;
    logic               req_acc;
    logic [ADDR_W-1:0]  rel_addr;

    assign cnt = (bcnt_reg > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : bcnt_reg;
    assign bsz = (bsz_reg == '0) ? BSZ_W'(1) : bsz_reg;
    assign s_ready = (state_reg == S_IDLE);
    assign req_acc = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid = out_valid_reg;
    assign m_data = out_reg;
    assign rel_addr = s_data.address;

    assign word_data = wvalid_reg[word_reg] ? rdata : '0;

    always_comb begin
        for (int i = 0; i < WORD_W; i++) begin
            pos = {1'b0, word_reg, BIT_W'(i)};
            cand[i] = !word_data[i] && (pos >= lo_reg) && (pos < cnt);
        end
        found = |cand;
        first = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (cand[i]) begin
                first = BIT_W'(i);
            end
        end
    end

    assign next_base = {(CNT_W - BIT_W)'(word_reg) + 1'b1, BIT_W'(0)};
    assign rel_bit = word_data[quo_reg[BIT_W-1:0]];
    assign shifted = {rem_reg[BSZ_W-2:0], quo_reg[OFS_W-1]};

    always_comb begin
        ram_we = 1'b0;
        ram_addr = word_reg;
        ram_wdata = word_data;
        case (state_reg)
            S_SCAN_CHK: begin
                ram_we = found;
                ram_wdata = word_data | (WORD_W'(1) << first);
            end
            S_REL_CHK: begin
                ram_we = rel_bit;
                ram_wdata = word_data & ~(WORD_W'(1) << quo_reg[BIT_W-1:0]);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    bba_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .raddr (ram_addr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            bsz_reg       <= BSZ_W'(64);
            doff_reg      <= OFS_W'(64);
            bcnt_reg      <= CNT_W'(1023);
            wvalid_reg    <= '0;
            used_reg      <= '0;
            hint_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_BLOCK_SIZE:  bsz_reg  <= cfg_data[BSZ_W-1:0];
                    CFG_DATA_OFFSET: doff_reg <= cfg_data[OFS_W-1:0];
                    CFG_BLOCK_COUNT: bcnt_reg <= cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid_reg && m_ready && state_reg != S_RES) begin
                out_valid_reg <= 1'b0;
            end
            if (ram_we) begin
                wvalid_reg[word_reg] <= 1'b1;
            end
            case (state_reg)
                S_IDLE: begin
                    if (req_acc) begin
                        idx_reg    <= '0;
                        ofs_reg    <= '0;
                        if (!s_data.kind) begin
                            if (used_reg >= cnt) begin
                                status_reg <= ST_NO_FREE;
                                state_reg  <= S_RES;
                            end else if (hint_reg < cnt) begin
                                status_reg <= ST_OK;
                                word_reg   <= hint_reg[IDX_W-1:BIT_W];
                                lo_reg     <= hint_reg;
                                pass_reg   <= 1'b0;
                                state_reg  <= S_SCAN_RD;
                            end else begin
                                status_reg <= ST_OK;
                                word_reg   <= '0;
                                lo_reg     <= '0;
                                pass_reg   <= 1'b1;
                                state_reg  <= S_SCAN_RD;
                            end
                        end else if (s_data.addr_is_null) begin
                            status_reg <= ST_NULL;
                            state_reg  <= S_RES;
                        end else if (rel_addr < ADDR_W'(doff_reg) ||
                                     rel_addr >= ADDR_W'(POOL_BYTES)) begin
                            status_reg <= ST_RANGE;
                            state_reg  <= S_RES;
                        end else begin
                            status_reg <= ST_OK;
                            quo_reg    <= rel_addr[OFS_W-1:0] - doff_reg;
                            rem_reg    <= '0;
                            dcnt_reg   <= 4'd15;
                            state_reg  <= S_DIV;
                        end
                    end
                end
                S_SCAN_RD: begin
                    state_reg <= S_SCAN_CHK;
                end
                S_SCAN_CHK: begin
                    if (found) begin
                        idx_reg   <= {word_reg, first};
                        used_reg  <= used_reg + 1'b1;
                        hint_reg  <= CNT_W'({word_reg, first}) + 1'b1;
                        state_reg <= S_MUL;
                    end else if (next_base < cnt) begin
                        word_reg  <= word_reg + 1'b1;
                        state_reg <= S_SCAN_RD;
                    end else if (!pass_reg && lo_reg != '0) begin
                        pass_reg  <= 1'b1;
                        word_reg  <= '0;
                        lo_reg    <= '0;
                        state_reg <= S_SCAN_RD;
                    end else begin
                        status_reg <= ST_NO_FREE;
                        state_reg  <= S_RES;
                    end
                end
                S_MUL: begin
                    prod_reg  <= 32'(idx_reg) * 32'(bsz[OFS_W-1:0]);
                    state_reg <= S_DCHK;
                    status_reg <= ST_OK;
                    pass_reg  <= 1'b1;
                end
                S_DIV: begin
                    quo_reg <= {quo_reg[OFS_W-2:0], (shifted >= bsz)};
                    rem_reg <= (shifted >= bsz) ? shifted - bsz : shifted;
                    dcnt_reg <= dcnt_reg - 1'b1;
                    if (dcnt_reg == '0) begin
                        pass_reg  <= 1'b0;
                        state_reg <= S_DCHK;
                    end
                end
                S_DCHK: begin
                    if (pass_reg) begin
                        ofs_reg   <= doff_reg + prod_reg[OFS_W-1:0];
                        state_reg <= S_RES;
                    end else if (rem_reg != '0) begin
                        status_reg <= ST_MISALIGNED;
                        state_reg  <= S_RES;
                    end else if (quo_reg[OFS_W-1:IDX_W] != '0) begin
                        status_reg <= ST_RANGE;
                        state_reg  <= S_RES;
                    end else begin
                        word_reg  <= quo_reg[IDX_W-1:BIT_W];
                        state_reg <= S_REL_RD;
                    end
                end
                S_REL_RD: begin
                    state_reg <= S_REL_CHK;
                end
                S_REL_CHK: begin
                    idx_reg <= quo_reg[IDX_W-1:0];
                    if (rel_bit) begin
                        used_reg <= used_reg - 1'b1;
                    end else begin
                        status_reg <= ST_DOUBLE;
                    end
                    state_reg <= S_RES;
                end
                S_RES: begin
                    if (!out_valid_reg || m_ready) begin
                        out_valid_reg       <= 1'b1;
                        out_reg.status       <= status_reg;
                        out_reg.block_offset <= ofs_reg;
                        out_reg.blk_idx      <= idx_reg;
                        out_reg.pool_full    <= (used_reg >= cnt);
                        out_reg.pool_empty   <= (used_reg == '0);
                        out_reg.used_blocks  <= used_reg;
                        state_reg            <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CNT_W'(MAX_BLOCKS))
        else $error("used count above capacity");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        req_acc |=> !s_ready)
        else $error("request taken while busy");

    a_write_in_check: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_SCAN_CHK || state_reg == S_REL_CHK))
        else $error("bitmap write outside check state");

endmodule

### rtl/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// generic single-port-write, registered-read ram
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
